### rtl/swm_pkg.sv
// ============================================================================
// Swerve module kinematics package
// Shared types, register indexes, fixed-point constants and the arctangent
// table used by the kinematics pipeline.
// ============================================================================
package swm_pkg;

    localparam int NUM_MODULES  = 4;
    localparam int CORDIC_STEPS = 17;
    localparam int DIV_BITS     = 20;
    localparam int CMDQ_DEPTH   = 2;
    localparam int OFIFO_DEPTH  = 4;

    localparam logic [2:0] REG_HALF_WHEEL_BASE  = 3'd0;
    localparam logic [2:0] REG_HALF_TRACK_WIDTH = 3'd1;
    localparam logic [2:0] REG_ROTATION_GAIN    = 3'd2;
    localparam logic [2:0] REG_WHEEL_RADIUS     = 3'd3;
    localparam logic [2:0] REG_SPEED_THRESHOLD  = 3'd4;

    localparam logic [15:0] RST_HALF_WHEEL_BASE  = 16'd13107;
    localparam logic [15:0] RST_HALF_TRACK_WIDTH = 16'd13107;
    localparam logic [15:0] RST_ROTATION_GAIN    = 16'd4096;
    localparam logic [15:0] RST_WHEEL_RADIUS     = 16'd4981;
    localparam logic [11:0] RST_SPEED_THRESHOLD  = 12'd4;

    // 1/K of the CORDIC in Q0.16, and pi/2 in Q.16 radians.
    localparam logic [15:0]        INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;
    localparam logic [19:0]        SPEED_MAX    = 20'hFFFFF;

    // One chassis command as it waits in the command queue.
    typedef struct packed {
        logic signed [15:0]       vel_x;
        logic signed [15:0]       vel_y;
        logic signed [31:0]       yaw_gain;
        logic [3:0][15:0]         angle_now;
    } t_cmd;

    // Side information that travels with one module through the pipeline.
    typedef struct packed {
        logic [1:0]  module_index;
        logic        last_module;
        logic [15:0] angle_now;
    } t_tag;

    // Per-module result fields that are settled before the divider.
    typedef struct packed {
        logic [1:0]  module_index;
        logic        last_module;
        logic [15:0] target_angle;
        logic        angle_held;
    } t_res;

    function automatic logic [15:0] f_atan(input int step);
        logic [15:0] v;
        case (step)
            0:       v = 16'd51472;
            1:       v = 16'd30386;
            2:       v = 16'd16055;
            3:       v = 16'd8150;
            4:       v = 16'd4091;
            5:       v = 16'd2047;
            6:       v = 16'd1024;
            7:       v = 16'd512;
            8:       v = 16'd256;
            9:       v = 16'd128;
            10:      v = 16'd64;
            11:      v = 16'd32;
            12:      v = 16'd16;
            13:      v = 16'd8;
            14:      v = 16'd4;
            15:      v = 16'd2;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

endpackage

### rtl/swerve_module_kinematics_unit.sv
// Path: a command passes two velocity stages, 18 CORDIC stages, two scaling
// stages, 21 divider stages and the output queue write before its first module
// result is on the output ports; the four results then follow one per cycle while
// the output queue has room.
// Throughput: the sequencer issues one module per cycle into the shared pipeline
// while the command queue holds a command and the output queue has room.
// Reset: synchronous active-low; queues empty, pipeline idle, registers at defaults.
// ============================================================================
// Swerve module kinematics unit
// Four-module swerve drive inverse kinematics: wheel velocity, CORDIC angle
// and magnitude, steering target and saturating drive speed per module.
// ============================================================================
module swerve_module_kinematics_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    // Command side.
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic signed [15:0] i_yaw_rate,
    input  logic signed [15:0] i_angle_now_fl,
    input  logic signed [15:0] i_angle_now_bl,
    input  logic signed [15:0] i_angle_now_br,
    input  logic signed [15:0] i_angle_now_fr,
    // Result side.
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_module_index,
    output logic signed [15:0] o_target_angle,
    output logic [19:0]        o_target_speed,
    output logic               o_angle_held,
    output logic               o_last_module
);
    import swm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must occur only while the unit is idle; not enforced.
    // ------------------------------------------------------------------
    logic [15:0] r_half_wheel_base, r_half_track_width, r_rotation_gain, r_wheel_radius;
    logic [11:0] r_speed_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_wheel_base  <= RST_HALF_WHEEL_BASE;
            r_half_track_width <= RST_HALF_TRACK_WIDTH;
            r_rotation_gain    <= RST_ROTATION_GAIN;
            r_wheel_radius     <= RST_WHEEL_RADIUS;
            r_speed_threshold  <= RST_SPEED_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALF_WHEEL_BASE:  r_half_wheel_base  <= i_cfg_wdata;
                REG_HALF_TRACK_WIDTH: r_half_track_width <= i_cfg_wdata;
                REG_ROTATION_GAIN:    r_rotation_gain    <= i_cfg_wdata;
                REG_WHEEL_RADIUS:     r_wheel_radius     <= i_cfg_wdata;
                REG_SPEED_THRESHOLD:  r_speed_threshold  <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: accepts commands and queues them, discarding any with zero wheel radius.
    // ------------------------------------------------------------------
    t_cmd q_head;
    logic q_empty, q_pop;

    swm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_yaw_rate      (i_yaw_rate),
        .i_angle_now_fl  (i_angle_now_fl),
        .i_angle_now_bl  (i_angle_now_bl),
        .i_angle_now_br  (i_angle_now_br),
        .i_angle_now_fr  (i_angle_now_fr),
        .i_rotation_gain (r_rotation_gain),
        .i_wheel_radius  (r_wheel_radius),
        .o_head          (q_head),
        .o_empty         (q_empty),
        .i_pop           (q_pop)
    );

    // ------------------------------------------------------------------
    // Back end. The whole pipeline advances together; it stalls only
    // while the output queue is full, so no result is ever dropped.
    // ------------------------------------------------------------------
    logic adv, issue, ofifo_full;
    logic [1:0] r_mod;

    assign adv   = !ofifo_full;
    assign issue = adv && !q_empty;
    // The command leaves the queue with the transfer of its last module.
    assign q_pop = issue && (r_mod == 2'(NUM_MODULES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
        end else if (issue) begin
            r_mod <= r_mod + 1'b1;
        end
    end

    // Stage 1: yaw contribution products for both axes.
    logic               r_s1_vld;
    logic signed [48:0] r_s1_px_prod, r_s1_py_prod;
    logic signed [15:0] r_s1_vx, r_s1_vy;
    t_tag               r_s1_tag;
    logic signed [16:0] w_px, w_py;

    // Module positions: front left (+B,+T), back left (-B,+T),
    // back right (-B,-T), front right (+B,-T).
    always_comb begin
        w_px = $signed({1'b0, r_half_wheel_base});
        w_py = $signed({1'b0, r_half_track_width});
        if (r_mod == 2'd1 || r_mod == 2'd2) w_px = -w_px;
        if (r_mod == 2'd2 || r_mod == 2'd3) w_py = -w_py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_px_prod           <= q_head.yaw_gain * w_px;
            r_s1_py_prod           <= q_head.yaw_gain * w_py;
            r_s1_vx                <= q_head.vel_x;
            r_s1_vy                <= q_head.vel_y;
            r_s1_tag.module_index  <= r_mod;
            r_s1_tag.last_module   <= (r_mod == 2'(NUM_MODULES - 1));
            r_s1_tag.angle_now     <= q_head.angle_now[r_mod];
        end
    end

    // Stage 2: wheel velocity in Q.20, yaw terms rounded to nearest.
    logic               r_s2_vld;
    logic signed [31:0] r_s2_wx, r_s2_wy;
    t_tag               r_s2_tag;
    logic signed [49:0] w_rx, w_ry;
    logic signed [31:0] w_vx256, w_vy256, w_yx, w_yy;

    assign w_rx    = 50'(r_s1_px_prod) + 50'sd524288;
    assign w_ry    = 50'(r_s1_py_prod) + 50'sd524288;
    assign w_yx    = 32'($signed(w_rx[49:20]));
    assign w_yy    = 32'($signed(w_ry[49:20]));
    assign w_vx256 = {{8{r_s1_vx[15]}}, r_s1_vx, 8'b0};
    assign w_vy256 = {{8{r_s1_vy[15]}}, r_s1_vy, 8'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_wx  <= w_vx256 + w_yx;
            r_s2_wy  <= w_vy256 - w_yy;
            r_s2_tag <= r_s1_tag;
        end
    end

    // CORDIC: magnitude (scaled by K) and atan2.
    logic               c_vld, c_zero;
    logic signed [31:0] c_x;
    logic signed [19:0] c_z;
    t_tag               c_tag;

    swm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s2_vld),
        .i_x     (r_s2_wx),
        .i_y     (r_s2_wy),
        .i_tag   (r_s2_tag),
        .o_vld   (c_vld),
        .o_x     (c_x),
        .o_z     (c_z),
        .o_zero  (c_zero),
        .o_tag   (c_tag)
    );

    // Stage 3: remove the CORDIC gain. x is never negative here.
    logic               r_s3_vld;
    logic [47:0]        r_s3_prod;
    logic signed [19:0] r_s3_z;
    t_tag               r_s3_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_prod <= $unsigned(c_x) * INV_GAIN_Q16;
            // A zero vector has its angle taken as zero.
            r_s3_z    <= c_zero ? '0 : c_z;
            r_s3_tag  <= c_tag;
        end
    end

    // Stage 4: magnitude rounding, threshold, steering target.
    logic               r_s4_vld;
    logic [35:0]        r_s4_num;
    t_res               r_s4_res;
    logic [47:0]        w_mag_r;
    logic [31:0]        w_mag;
    logic               w_held;
    logic signed [20:0] w_za;
    logic signed [16:0] w_a;
    logic [15:0]        w_angle;

    assign w_mag_r = r_s3_prod + 48'd32768;
    assign w_mag   = w_mag_r[47:16];
    assign w_held  = (w_mag < {12'b0, r_speed_threshold, 8'b0});
    assign w_za    = 21'(r_s3_z) - 21'(HALF_PI_Q16) + 21'sd8;
    assign w_a     = w_za[20:4];

    always_comb begin
        if (w_a[16] != w_a[15]) begin
            w_angle = w_a[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            w_angle = w_a[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (adv) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // A held module divides zero, which gives zero speed.
            r_s4_num              <= w_held ? '0 : {w_mag, 4'b0};
            r_s4_res.module_index <= r_s3_tag.module_index;
            r_s4_res.last_module  <= r_s3_tag.last_module;
            r_s4_res.target_angle <= w_held ? r_s3_tag.angle_now : w_angle;
            r_s4_res.angle_held   <= w_held;
        end
    end

    // Drive speed: magnitude * 16 / wheel radius, saturating.
    logic        d_vld;
    logic [19:0] d_quot;
    t_res        d_res;

    swm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s4_vld),
        .i_num   (r_s4_num),
        .i_den   (r_wheel_radius),
        .i_res   (r_s4_res),
        .o_vld   (d_vld),
        .o_quot  (d_quot),
        .o_res   (d_res)
    );

    // ------------------------------------------------------------------
    // Output queue. Results are written only while the pipeline advances,
    // which is only while there is room.
    // ------------------------------------------------------------------
    localparam int OAW = $clog2(OFIFO_DEPTH);

    typedef struct packed {
        t_res        res;
        logic [19:0] speed;
    } t_out;

    t_out           r_omem [OFIFO_DEPTH];
    logic [OAW-1:0] r_owr, r_ord;
    logic [OAW:0]   r_ocnt;
    logic           owr, ord;
    t_out           w_out, w_head;

    assign ofifo_full = (r_ocnt == (OAW+1)'(OFIFO_DEPTH));
    assign empty      = (r_ocnt == '0);
    assign owr        = adv && d_vld;
    assign ord        = pop && !empty;
    assign w_out.res   = d_res;
    assign w_out.speed = d_quot;

    always_ff @(posedge i_clk) begin
        if (owr) begin
            r_omem[r_owr] <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (owr) r_owr <= r_owr + 1'b1;
            if (ord) r_ord <= r_ord + 1'b1;
            r_ocnt <= r_ocnt + (OAW+1)'(owr) - (OAW+1)'(ord);
        end
    end

    assign w_head         = r_omem[r_ord];
    assign o_module_index = w_head.res.module_index;
    assign o_target_angle = w_head.res.target_angle;
    assign o_target_speed = w_head.speed;
    assign o_angle_held   = w_head.res.angle_held;
    assign o_last_module  = w_head.res.last_module;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ofifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (OAW+1)'(OFIFO_DEPTH))
        else $error("output queue count beyond depth");

    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_angle_held) |-> (o_target_speed == '0))
        else $error("held module with nonzero speed");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_module == (o_module_index == 2'(NUM_MODULES - 1))))
        else $error("last flag does not match module index");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && r_s4_vld) |=> (r_s4_vld && $stable(r_s4_num)))
        else $error("pipeline moved during a stall");

    a_seq_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (r_mod == '0))
        else $error("command left the queue before its last module");

endmodule

### rtl/swm_front.sv
// ============================================================================
// Swerve kinematics command front end
// Accepts chassis commands, drops them when the wheel radius is zero, forms
// the scaled yaw rate and keeps the commands in a short queue.
// ============================================================================
module swm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic signed [15:0] i_yaw_rate,
    input  logic signed [15:0] i_angle_now_fl,
    input  logic signed [15:0] i_angle_now_bl,
    input  logic signed [15:0] i_angle_now_br,
    input  logic signed [15:0] i_angle_now_fr,
    input  logic [15:0]        i_rotation_gain,
    input  logic [15:0]        i_wheel_radius,
    output swm_pkg::t_cmd      o_head,
    output logic               o_empty,
    input  logic               i_pop
);
    import swm_pkg::*;

    localparam int AW = $clog2(CMDQ_DEPTH);

    t_cmd            r_mem [CMDQ_DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [AW:0]     r_count;
    logic            accept, store, take;
    t_cmd            w_cmd;
    logic signed [32:0] w_wg;

    assign full    = (r_count == (AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign accept  = push && !full;
    // A zero wheel radius yields no results, so such a command is discarded.
    assign store   = accept && (i_wheel_radius != '0);
    assign take    = i_pop && !o_empty;

    assign w_wg = i_yaw_rate * $signed({1'b0, i_rotation_gain});

    always_comb begin
        w_cmd.vel_x        = i_vel_x;
        w_cmd.vel_y        = i_vel_y;
        w_cmd.yaw_gain     = w_wg[31:0];
        w_cmd.angle_now[0] = i_angle_now_fl;
        w_cmd.angle_now[1] = i_angle_now_bl;
        w_cmd.angle_now[2] = i_angle_now_br;
        w_cmd.angle_now[3] = i_angle_now_fr;
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (store) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (take)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (AW+1)'(store) - (AW+1)'(take);
        end
    end

    assign o_head = r_mem[r_rd_ptr];

endmodule

### rtl/swm_cordic.sv
// ============================================================================
// Swerve kinematics CORDIC pipeline
// Vectoring-mode CORDIC, one stage per step, giving the scaled magnitude and
// the angle of a wheel velocity vector.
// ============================================================================
module swm_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  swm_pkg::t_tag      i_tag,
    output logic               o_vld,
    output logic signed [31:0] o_x,
    output logic signed [19:0] o_z,
    output logic               o_zero,
    output swm_pkg::t_tag      o_tag
);
    import swm_pkg::*;

    logic               r_vld  [CORDIC_STEPS+1];
    logic signed [31:0] r_x    [CORDIC_STEPS+1];
    logic signed [31:0] r_y    [CORDIC_STEPS+1];
    logic signed [19:0] r_z    [CORDIC_STEPS+1];
    logic               r_zero [CORDIC_STEPS+1];
    t_tag               r_tag  [CORDIC_STEPS+1];

    // Pre-rotation brings the vector into the right half plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= i_tag;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= HALF_PI_Q16;
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -HALF_PI_Q16;
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        logic signed [31:0] dx, dy;
        logic signed [19:0] da;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        assign da = $signed({4'b0, f_atan(g)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[g+1]  <= r_tag[g];
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + da;
                end else begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - da;
                end
            end
        end
    end

    assign o_vld  = r_vld[CORDIC_STEPS];
    assign o_x    = r_x[CORDIC_STEPS];
    assign o_z    = r_z[CORDIC_STEPS];
    assign o_zero = r_zero[CORDIC_STEPS];
    assign o_tag  = r_tag[CORDIC_STEPS];

endmodule

### rtl/swm_div.sv
// ============================================================================
// Swerve kinematics speed divider
// Pipelined restoring divider, one quotient bit per stage, saturating the
// quotient at its 20-bit maximum.
// ============================================================================
module swm_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [35:0]   i_num,
    input  logic [15:0]   i_den,
    input  swm_pkg::t_res i_res,
    output logic          o_vld,
    output logic [19:0]   o_quot,
    output swm_pkg::t_res o_res
);
    import swm_pkg::*;

    logic          r_vld [DIV_BITS+1];
    logic [35:0]   r_rem [DIV_BITS+1];
    logic [19:0]   r_q   [DIV_BITS+1];
    logic          r_sat [DIV_BITS+1];
    t_res          r_res [DIV_BITS+1];

    // The quotient overflows exactly when the numerator reaches den * 2^20.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
            r_sat[0] <= (i_num >= {i_den, 20'b0});
            r_res[0] <= i_res;
        end
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_bit
        localparam int B = DIV_BITS - 1 - g;
        logic [35:0] d;
        assign d = {20'b0, i_den} << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[g+1] <= r_sat[g];
                r_res[g+1] <= r_res[g];
                if (!r_sat[g] && (r_rem[g] >= d)) begin
                    r_rem[g+1] <= r_rem[g] - d;
                    r_q[g+1]   <= r_q[g] | (20'd1 << B);
                end else begin
                    r_rem[g+1] <= r_rem[g];
                    r_q[g+1]   <= r_q[g];
                end
            end
        end
    end

    assign o_vld  = r_vld[DIV_BITS];
    assign o_quot = r_sat[DIV_BITS] ? SPEED_MAX : r_q[DIV_BITS];
    assign o_res  = r_res[DIV_BITS];

endmodule
